// File: rtl/mlk_pkg.sv
// package: shared types, constants and sequencing functions of the morse letter keyer
package mlk_pkg;

    localparam int TIMER_WIDTH = 22;
    localparam int TONE_WIDTH  = 16;
    localparam int CFG_DATA_W  = 22;
    localparam int CFG_IDX_W   = 3;
    localparam int CHAIN_STEPS = 9;

    localparam logic [7:0] CODE_A = 8'h41;
    localparam logic [7:0] CODE_Z = 8'h5A;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_DOT  = 2'd1;
    localparam logic [1:0] MARK_DASH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_TICKS        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_TICKS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LETTER_GAP_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_HALF_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_TONE_TICKS = 3'd6;

    localparam logic [TIMER_WIDTH-1:0] DOT_TICKS_RST        = 22'd200000;
    localparam logic [TIMER_WIDTH-1:0] DASH_TICKS_RST       = 22'd800000;
    localparam logic [TIMER_WIDTH-1:0] GAP_TICKS_RST        = 22'd125000;
    localparam logic [TIMER_WIDTH-1:0] LETTER_GAP_TICKS_RST = 22'd125000;
    localparam logic [TONE_WIDTH-1:0]  TONE_HALF_TICKS_RST  = 16'd500;
    localparam logic [TIMER_WIDTH-1:0] ERROR_TONE_TICKS_RST = 22'd3000000;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_KEY_ON,
        PH_KEY_OFF,
        PH_LETTER_GAP,
        PH_ERROR_TONE
    } phase_t;

    typedef enum logic [2:0] {
        LD_KEEP,
        LD_DOT,
        LD_DASH,
        LD_GAP,
        LD_LGAP,
        LD_ERR,
        LD_ZERO
    } load_t;

    typedef struct packed {
        logic       letter_valid;
        logic [7:0] letter_code;
    } in_word_t;

    typedef struct packed {
        logic       led_level;
        logic       buzzer_level;
        logic       busy_res;
        logic       accepted;
        logic       error;
        logic [1:0] symbol_mark;
    } out_word_t;

    typedef struct packed {
        logic                   output_mode;
        logic [TIMER_WIDTH-1:0] dot_ticks;
        logic [TIMER_WIDTH-1:0] dash_ticks;
        logic [TIMER_WIDTH-1:0] gap_ticks;
        logic [TIMER_WIDTH-1:0] letter_gap_ticks;
        logic [TONE_WIDTH-1:0]  tone_half_ticks;
        logic [TIMER_WIDTH-1:0] error_tone_ticks;
    } cfg_t;

    typedef struct packed {
        logic dot;
        logic dash;
        logic gap;
        logic lgap;
        logic err;
    } zero_t;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] pattern;
        logic [2:0] left;
        load_t      load;
        logic       tone_level;
        logic       tone_clr;
        logic [1:0] mark;
    } seq_t;

    // high nibble length, low nibble symbols with bit 0 first, 1 = dash
    function automatic logic [7:0] morse_entry(input logic [4:0] idx);
        logic [7:0] e;
        case (idx)
            5'd0:    e = 8'h22;
            5'd1:    e = 8'h41;
            5'd2:    e = 8'h45;
            5'd3:    e = 8'h31;
            5'd4:    e = 8'h10;
            5'd5:    e = 8'h44;
            5'd6:    e = 8'h33;
            5'd7:    e = 8'h40;
            5'd8:    e = 8'h20;
            5'd9:    e = 8'h4E;
            5'd10:   e = 8'h35;
            5'd11:   e = 8'h42;
            5'd12:   e = 8'h23;
            5'd13:   e = 8'h21;
            5'd14:   e = 8'h37;
            5'd15:   e = 8'h46;
            5'd16:   e = 8'h4B;
            5'd17:   e = 8'h32;
            5'd18:   e = 8'h30;
            5'd19:   e = 8'h11;
            5'd20:   e = 8'h34;
            5'd21:   e = 8'h48;
            5'd22:   e = 8'h36;
            5'd23:   e = 8'h49;
            5'd24:   e = 8'h4D;
            5'd25:   e = 8'h43;
            default: e = 8'h00;
        endcase
        return e;
    endfunction

    function automatic logic load_zero(input load_t ld, input zero_t z);
        logic r;
        case (ld)
            LD_DOT:  r = z.dot;
            LD_DASH: r = z.dash;
            LD_GAP:  r = z.gap;
            LD_LGAP: r = z.lgap;
            LD_ERR:  r = z.err;
            LD_ZERO: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [TIMER_WIDTH-1:0] load_value(input load_t ld, input cfg_t c,
                                                          input logic [TIMER_WIDTH-1:0] keep);
        logic [TIMER_WIDTH-1:0] v;
        case (ld)
            LD_KEEP: v = keep;
            LD_DOT:  v = c.dot_ticks;
            LD_DASH: v = c.dash_ticks;
            LD_GAP:  v = c.gap_ticks;
            LD_LGAP: v = c.letter_gap_ticks;
            LD_ERR:  v = c.error_tone_ticks;
            default: v = '0;
        endcase
        return v;
    endfunction

    // one phase transition
    function automatic seq_t seq_step(input seq_t s);
        seq_t n;
        n = s;
        case (s.phase)
            PH_KEY_ON:
            begin
                n.phase      = PH_KEY_OFF;
                n.load       = LD_GAP;
                n.tone_level = 1'b0;
            end
            PH_KEY_OFF:
            begin
                n.mark    = s.pattern[0] ? MARK_DASH : MARK_DOT;
                n.pattern = {1'b0, s.pattern[3:1]};
                n.left    = s.left - 3'd1;
                if (n.left != 3'd0)
                begin
                    n.phase      = PH_KEY_ON;
                    n.load       = n.pattern[0] ? LD_DASH : LD_DOT;
                    n.tone_clr   = 1'b1;
                    n.tone_level = 1'b1;
                end
                else
                begin
                    n.phase = PH_LETTER_GAP;
                    n.load  = LD_LGAP;
                end
            end
            default:
            begin
                n.phase      = PH_IDLE;
                n.load       = LD_ZERO;
                n.tone_level = 1'b0;
            end
        endcase
        return n;
    endfunction

    // leave the current phase, skipping phases of zero length
    function automatic seq_t seq_run(input seq_t s, input zero_t z);
        seq_t r;
        logic run;
        r   = s;
        run = 1'b1;
        for (int i = 0; i < CHAIN_STEPS; i++)
        begin
            if (run)
            begin
                r   = seq_step(r);
                run = (r.phase != PH_IDLE) && load_zero(r.load, z);
            end
        end
        return r;
    endfunction

endpackage

// File: rtl/mlk_cfg_regs.sv
// configuration register file of the morse letter keyer
module mlk_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlk_pkg::CFG_DATA_W-1:0]  cfg_data,
    output mlk_pkg::cfg_t                   cfg
);

    mlk_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_mode      <= 1'b0;
            cfg_reg.dot_ticks        <= mlk_pkg::DOT_TICKS_RST;
            cfg_reg.dash_ticks       <= mlk_pkg::DASH_TICKS_RST;
            cfg_reg.gap_ticks        <= mlk_pkg::GAP_TICKS_RST;
            cfg_reg.letter_gap_ticks <= mlk_pkg::LETTER_GAP_TICKS_RST;
            cfg_reg.tone_half_ticks  <= mlk_pkg::TONE_HALF_TICKS_RST;
            cfg_reg.error_tone_ticks <= mlk_pkg::ERROR_TONE_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mlk_pkg::REG_OUTPUT_MODE:      cfg_reg.output_mode      <= cfg_data[0];
                mlk_pkg::REG_DOT_TICKS:        cfg_reg.dot_ticks        <= cfg_data;
                mlk_pkg::REG_DASH_TICKS:       cfg_reg.dash_ticks       <= cfg_data;
                mlk_pkg::REG_GAP_TICKS:        cfg_reg.gap_ticks        <= cfg_data;
                mlk_pkg::REG_LETTER_GAP_TICKS: cfg_reg.letter_gap_ticks <= cfg_data;
                mlk_pkg::REG_TONE_HALF_TICKS:
                    cfg_reg.tone_half_ticks <= cfg_data[mlk_pkg::TONE_WIDTH-1:0];
                mlk_pkg::REG_ERROR_TONE_TICKS: cfg_reg.error_tone_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/mlk_engine.sv
// keying state and single-pass next-state and result logic of the morse letter keyer
module mlk_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  mlk_pkg::in_word_t  in_word,
    input  mlk_pkg::cfg_t      cfg,
    output mlk_pkg::out_word_t res
);

    mlk_pkg::phase_t                   phase_reg;
    logic [3:0]                        pattern_reg;
    logic [2:0]                        left_reg;
    logic [mlk_pkg::TIMER_WIDTH-1:0]   countdown_reg;
    logic [mlk_pkg::TONE_WIDTH-1:0]    tone_cnt_reg;
    logic                              tone_level_reg;
    logic                              led_hold_reg;
    logic                              buz_hold_reg;

    mlk_pkg::seq_t                     s0;
    mlk_pkg::seq_t                     s1;
    mlk_pkg::seq_t                     s2;
    mlk_pkg::zero_t                    z;
    logic                              take;
    logic                              letter_ok;
    logic [4:0]                        letter_off;
    logic [7:0]                        entry;
    logic                              led_hold_next;
    logic                              buz_hold_next;
    logic [mlk_pkg::TIMER_WIDTH-1:0]   cd1;
    logic [mlk_pkg::TIMER_WIDTH-1:0]   cd_dec;
    logic [mlk_pkg::TIMER_WIDTH-1:0]   countdown_next;
    logic [mlk_pkg::TONE_WIDTH-1:0]    tc1;
    logic [mlk_pkg::TONE_WIDTH-1:0]    tc_inc;
    logic [mlk_pkg::TONE_WIDTH-1:0]    tc2;
    logic [mlk_pkg::TONE_WIDTH-1:0]    half;
    logic [mlk_pkg::TONE_WIDTH-1:0]    tone_cnt_next;
    logic                              tl2;
    logic                              tone_level_next;
    logic                              led;
    logic                              buz;
    logic                              busy;

    assign z.dot  = (cfg.dot_ticks == '0);
    assign z.dash = (cfg.dash_ticks == '0);
    assign z.gap  = (cfg.gap_ticks == '0);
    assign z.lgap = (cfg.letter_gap_ticks == '0);
    assign z.err  = (cfg.error_tone_ticks == '0);

    assign letter_ok  = in_word.letter_code inside {[mlk_pkg::CODE_A:mlk_pkg::CODE_Z]};
    assign letter_off = 5'(in_word.letter_code - mlk_pkg::CODE_A);
    assign entry      = mlk_pkg::morse_entry(letter_off);
    assign take       = in_word.letter_valid && (phase_reg == mlk_pkg::PH_IDLE);
    assign half       = (cfg.tone_half_ticks == '0) ? 16'd1 : cfg.tone_half_ticks;

    always_comb
    begin
        s0.phase      = phase_reg;
        s0.pattern    = pattern_reg;
        s0.left       = left_reg;
        s0.load       = mlk_pkg::LD_KEEP;
        s0.tone_level = tone_level_reg;
        s0.tone_clr   = 1'b0;
        s0.mark       = mlk_pkg::MARK_NONE;
        led_hold_next = led_hold_reg;
        buz_hold_next = buz_hold_reg;

        // letter intake
        if (take)
        begin
            led_hold_next = 1'b0;
            buz_hold_next = 1'b0;
            if (letter_ok)
            begin
                s0.pattern    = entry[3:0];
                s0.left       = entry[6:4];
                s0.phase      = mlk_pkg::PH_KEY_ON;
                s0.load       = entry[0] ? mlk_pkg::LD_DASH : mlk_pkg::LD_DOT;
                s0.tone_clr   = 1'b1;
                s0.tone_level = 1'b1;
            end
            else
            begin
                led_hold_next = 1'b1;
                if (cfg.output_mode)
                begin
                    buz_hold_next = 1'b1;
                end
                else
                begin
                    s0.phase      = mlk_pkg::PH_ERROR_TONE;
                    s0.load       = mlk_pkg::LD_ERR;
                    s0.tone_clr   = 1'b1;
                    s0.tone_level = 1'b1;
                end
            end
        end

        if (take && (s0.phase != mlk_pkg::PH_IDLE) && mlk_pkg::load_zero(s0.load, z))
            s1 = mlk_pkg::seq_run(s0, z);
        else
            s1 = s0;

        cd1    = mlk_pkg::load_value(s1.load, cfg, countdown_reg);
        cd_dec = cd1 - 22'd1;
        tc1    = s1.tone_clr ? '0 : tone_cnt_reg;
        tc_inc = tc1 + 16'd1;

        // one tick of the current phase
        led  = led_hold_next;
        buz  = buz_hold_next;
        busy = 1'b0;
        tc2  = tc1;
        tl2  = s1.tone_level;
        if (s1.phase inside {mlk_pkg::PH_KEY_ON, mlk_pkg::PH_ERROR_TONE})
        begin
            if ((s1.phase == mlk_pkg::PH_KEY_ON) && !cfg.output_mode)
                led = 1'b1;
            if ((s1.phase == mlk_pkg::PH_ERROR_TONE) || cfg.output_mode)
                buz = buz | s1.tone_level;
            if (tc_inc >= half)
            begin
                tc2 = '0;
                tl2 = ~s1.tone_level;
            end
            else
            begin
                tc2 = tc_inc;
            end
        end

        s2              = s1;
        countdown_next  = cd1;
        tone_cnt_next   = tc2;
        tone_level_next = tl2;
        if (s1.phase != mlk_pkg::PH_IDLE)
        begin
            busy           = 1'b1;
            countdown_next = cd_dec;
            if (cd_dec == '0)
            begin
                s2            = s1;
                s2.tone_level = tl2;
                s2.tone_clr   = 1'b0;
                s2            = mlk_pkg::seq_run(s2, z);
                countdown_next  = mlk_pkg::load_value(s2.load, cfg, cd_dec);
                tone_cnt_next   = s2.tone_clr ? '0 : tc2;
                tone_level_next = s2.tone_level;
            end
        end

        res.led_level    = led;
        res.buzzer_level = buz;
        res.busy_res     = busy;
        res.accepted     = take;
        res.error        = take && !letter_ok;
        res.symbol_mark  = s2.mark;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= mlk_pkg::PH_IDLE;
            pattern_reg    <= '0;
            left_reg       <= '0;
            countdown_reg  <= '0;
            tone_cnt_reg   <= '0;
            tone_level_reg <= 1'b0;
            led_hold_reg   <= 1'b0;
            buz_hold_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= s2.phase;
            pattern_reg    <= s2.pattern;
            left_reg       <= s2.left;
            countdown_reg  <= countdown_next;
            tone_cnt_reg   <= tone_cnt_next;
            tone_level_reg <= tone_level_next;
            led_hold_reg   <= led_hold_next;
            buz_hold_reg   <= buz_hold_next;
        end
    end

endmodule

// File: rtl/morse_letter_keyer_core.sv
// top level of the morse letter keyer: config registers, keying engine, result register
// the result word of a tick word is registered on the edge that takes it
// throughput: one tick word per cycle while in_stall is low, set by the single-pass keying state update
// in_stall is high only while the result register is full and out_stall holds it
// reset: keyer idle, holds and tone cleared, timing registers at their defaults,
// result register empty
module morse_letter_keyer_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mlk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mlk_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  mlk_pkg::in_word_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output mlk_pkg::out_word_t              out_data
);

    mlk_pkg::cfg_t      cfg;
    mlk_pkg::out_word_t res;
    mlk_pkg::out_word_t out_data_reg;
    logic               out_valid_reg;
    logic               step;

    assign in_stall = out_valid_reg && out_stall;
    assign step     = in_valid && !in_stall;

    mlk_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mlk_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_word (in_data),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: rtl/mlk_checker.sv
// port checker of the morse letter keyer and its bind
module mlk_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input logic                            out_valid,
    input logic                            out_stall,
    input mlk_pkg::out_word_t              out_data
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // input is only held back by a full, stalled result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    // an accepted tick word yields a result word on the next edge
    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word produced no result");

    // errors only on taken characters, marks are none, dot or dash
    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.accepted || !out_data.error) &&
                      (out_data.symbol_mark <= mlk_pkg::MARK_DASH))
        else $error("inconsistent result word");

endmodule

bind morse_letter_keyer_core mlk_checker u_mlk_checker (.*);

// File: bench/tb.sv
// testbench of the morse letter keyer core: tick words against a keying predictor
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          REPORT_CAP     = 50;
    localparam int unsigned TIMER_MAX      = (1 << mlk_pkg::TIMER_WIDTH) - 1;
    localparam int unsigned TONE_MAX       = (1 << mlk_pkg::TONE_WIDTH) - 1;

    // length in the high nibble, first symbol in bit 0, 1 = dash
    localparam logic [7:0] GLYPHS [26] = '{
        8'h22, 8'h41, 8'h45, 8'h31, 8'h10, 8'h44, 8'h33, 8'h40, 8'h20, 8'h4E,
        8'h35, 8'h42, 8'h23, 8'h21, 8'h37, 8'h46, 8'h4B, 8'h32, 8'h30, 8'h11,
        8'h34, 8'h48, 8'h36, 8'h49, 8'h4D, 8'h43
    };

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [mlk_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mlk_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    mlk_pkg::in_word_t              in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    mlk_pkg::out_word_t             out_data;

    mlk_pkg::in_word_t  tick_words[$];
    mlk_pkg::out_word_t predicted_pins[$];

    int send_gap_pct = 0;
    int stall_pct    = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;

    mlk_pkg::cfg_t keyer_cfg = '{
        output_mode:      1'b0,
        dot_ticks:        mlk_pkg::DOT_TICKS_RST,
        dash_ticks:       mlk_pkg::DASH_TICKS_RST,
        gap_ticks:        mlk_pkg::GAP_TICKS_RST,
        letter_gap_ticks: mlk_pkg::LETTER_GAP_TICKS_RST,
        tone_half_ticks:  mlk_pkg::TONE_HALF_TICKS_RST,
        error_tone_ticks: mlk_pkg::ERROR_TONE_TICKS_RST
    };

    mlk_pkg::phase_t                 k_phase    = mlk_pkg::PH_IDLE;
    logic [3:0]                      k_pattern  = '0;
    logic [2:0]                      k_left     = '0;
    logic [mlk_pkg::TIMER_WIDTH-1:0] k_count    = '0;
    logic [mlk_pkg::TONE_WIDTH-1:0]  k_tone_cnt = '0;
    logic                            k_tone_lvl = 1'b0;
    logic                            led_hold   = 1'b0;
    logic                            buz_hold   = 1'b0;

    morse_letter_keyer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void start_symbol();
        k_phase    = mlk_pkg::PH_KEY_ON;
        k_count    = k_pattern[0] ? keyer_cfg.dash_ticks : keyer_cfg.dot_ticks;
        k_tone_cnt = '0;
        k_tone_lvl = 1'b1;
    endfunction

    // leave the current phase, skipping any of zero length
    function automatic void leave_phase(inout logic [1:0] mark);
        do
        begin
            case (k_phase)
                mlk_pkg::PH_KEY_ON:
                begin
                    k_phase    = mlk_pkg::PH_KEY_OFF;
                    k_count    = keyer_cfg.gap_ticks;
                    k_tone_lvl = 1'b0;
                end
                mlk_pkg::PH_KEY_OFF:
                begin
                    mark      = k_pattern[0] ? mlk_pkg::MARK_DASH : mlk_pkg::MARK_DOT;
                    k_pattern = k_pattern >> 1;
                    k_left    = k_left - 3'd1;
                    if (k_left != 3'd0)
                    begin
                        start_symbol();
                    end
                    else
                    begin
                        k_phase = mlk_pkg::PH_LETTER_GAP;
                        k_count = keyer_cfg.letter_gap_ticks;
                    end
                end
                default:
                begin
                    k_phase    = mlk_pkg::PH_IDLE;
                    k_count    = '0;
                    k_tone_lvl = 1'b0;
                end
            endcase
        end
        while (k_phase != mlk_pkg::PH_IDLE && k_count == '0);
    endfunction

    // pin levels and flags of one tick, advancing the keyer state
    function automatic mlk_pkg::out_word_t play_tick(input mlk_pkg::in_word_t w);
        mlk_pkg::out_word_t             r;
        logic [7:0]                     g;
        logic [4:0]                     gi;
        logic [1:0]                     mark;
        logic [mlk_pkg::TONE_WIDTH-1:0] half;
        r    = '0;
        mark = mlk_pkg::MARK_NONE;
        if (k_phase == mlk_pkg::PH_IDLE && w.letter_valid)
        begin
            r.accepted = 1'b1;
            led_hold   = 1'b0;
            buz_hold   = 1'b0;
            if (w.letter_code inside {[mlk_pkg::CODE_A:mlk_pkg::CODE_Z]})
            begin
                gi        = 5'(w.letter_code - mlk_pkg::CODE_A);
                g         = GLYPHS[gi];
                k_pattern = g[3:0];
                k_left    = g[6:4];
                start_symbol();
            end
            else
            begin
                r.error  = 1'b1;
                led_hold = 1'b1;
                if (keyer_cfg.output_mode)
                begin
                    buz_hold = 1'b1;
                end
                else
                begin
                    k_phase    = mlk_pkg::PH_ERROR_TONE;
                    k_count    = keyer_cfg.error_tone_ticks;
                    k_tone_cnt = '0;
                    k_tone_lvl = 1'b1;
                end
            end
            if (k_phase != mlk_pkg::PH_IDLE && k_count == '0)
                leave_phase(mark);
        end
        r.led_level    = led_hold;
        r.buzzer_level = buz_hold;
        if (k_phase != mlk_pkg::PH_IDLE)
        begin
            r.busy_res = 1'b1;
            if (k_phase inside {mlk_pkg::PH_KEY_ON, mlk_pkg::PH_ERROR_TONE})
            begin
                half = (keyer_cfg.tone_half_ticks == '0) ? 16'd1 : keyer_cfg.tone_half_ticks;
                if (k_phase == mlk_pkg::PH_KEY_ON && !keyer_cfg.output_mode)
                    r.led_level = 1'b1;
                if (k_phase == mlk_pkg::PH_ERROR_TONE || keyer_cfg.output_mode)
                    r.buzzer_level = r.buzzer_level | k_tone_lvl;
                k_tone_cnt = k_tone_cnt + 16'd1;
                if (k_tone_cnt >= half)
                begin
                    k_tone_cnt = '0;
                    k_tone_lvl = ~k_tone_lvl;
                end
            end
            k_count = k_count - 22'd1;
            if (k_count == '0)
                leave_phase(mark);
        end
        r.symbol_mark = mark;
        return r;
    endfunction

    function automatic void check_pin(input string what, input logic [1:0] want,
                                      input logic [1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // tick word driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predicted_pins.push_back(play_tick(in_data));
            if (!in_valid || !in_stall)
            begin
                if (tick_words.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    in_data  <= tick_words.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result word monitor
    always @(posedge clk)
    begin
        mlk_pkg::out_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (predicted_pins.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t unexpected word: expected none, got %h", $time, out_data);
                end
                else
                begin
                    want = predicted_pins.pop_front();
                    check_pin("led_level", 2'(want.led_level), 2'(out_data.led_level));
                    check_pin("buzzer_level", 2'(want.buzzer_level),
                              2'(out_data.buzzer_level));
                    check_pin("busy_res", 2'(want.busy_res), 2'(out_data.busy_res));
                    check_pin("accepted", 2'(want.accepted), 2'(out_data.accepted));
                    check_pin("error", 2'(want.error), 2'(out_data.error));
                    check_pin("symbol_mark", want.symbol_mark, out_data.symbol_mark);
                end
            end
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no word moved for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic offer(input logic v, input logic [7:0] c);
        mlk_pkg::in_word_t w;
        w.letter_valid = v;
        w.letter_code  = c;
        tick_words.push_back(w);
    endtask

    // wait for all words to drain; with to_idle, tick the keyer back to idle too
    task automatic settle(input bit to_idle);
        @(negedge clk);
        while (tick_words.size() != 0 || in_valid || predicted_pins.size() != 0 ||
               (to_idle && k_phase != mlk_pkg::PH_IDLE))
        begin
            if (to_idle && tick_words.size() == 0 && !in_valid && k_phase != mlk_pkg::PH_IDLE)
                offer(1'b0, 8'($urandom));
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [mlk_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[mlk_pkg::CFG_DATA_W-1:0];
        case (idx)
            mlk_pkg::REG_OUTPUT_MODE:
                keyer_cfg.output_mode      = val[0];
            mlk_pkg::REG_DOT_TICKS:
                keyer_cfg.dot_ticks        = val[mlk_pkg::TIMER_WIDTH-1:0];
            mlk_pkg::REG_DASH_TICKS:
                keyer_cfg.dash_ticks       = val[mlk_pkg::TIMER_WIDTH-1:0];
            mlk_pkg::REG_GAP_TICKS:
                keyer_cfg.gap_ticks        = val[mlk_pkg::TIMER_WIDTH-1:0];
            mlk_pkg::REG_LETTER_GAP_TICKS:
                keyer_cfg.letter_gap_ticks = val[mlk_pkg::TIMER_WIDTH-1:0];
            mlk_pkg::REG_TONE_HALF_TICKS:
                keyer_cfg.tone_half_ticks  = val[mlk_pkg::TONE_WIDTH-1:0];
            mlk_pkg::REG_ERROR_TONE_TICKS:
                keyer_cfg.error_tone_ticks = val[mlk_pkg::TIMER_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic load_timing(input int unsigned mode, input int unsigned dot,
                               input int unsigned dash, input int unsigned gap,
                               input int unsigned lgap, input int unsigned half,
                               input int unsigned errt);
        write_reg(mlk_pkg::REG_OUTPUT_MODE, mode);
        write_reg(mlk_pkg::REG_DOT_TICKS, dot);
        write_reg(mlk_pkg::REG_DASH_TICKS, dash);
        write_reg(mlk_pkg::REG_GAP_TICKS, gap);
        write_reg(mlk_pkg::REG_LETTER_GAP_TICKS, lgap);
        write_reg(mlk_pkg::REG_TONE_HALF_TICKS, half);
        write_reg(mlk_pkg::REG_ERROR_TONE_TICKS, errt);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        send_gap_pct = 18;
        stall_pct    = 52;
        settle(1'b1);

        // zero gaps, zero error tone, zero half period, letter range edges
        load_timing(0, 1, 2, 0, 0, 0, 0);
        offer(1'b1, "A");
        offer(1'b1, "E");
        offer(1'b1, "Z");
        offer(1'b1, mlk_pkg::CODE_A - 8'd1);
        offer(1'b1, mlk_pkg::CODE_Z + 8'd1);
        offer(1'b1, 8'h00);
        offer(1'b1, 8'hFF);
        offer(1'b1, "E");
        settle(1'b1);

        // tone mode, error holds cleared by the next letter
        load_timing(1, 2, 3, 1, 2, 1, 5);
        offer(1'b1, mlk_pkg::CODE_A - 8'd1);
        offer(1'b0, "T");
        offer(1'b1, "T");
        offer(1'b1, "Q");
        offer(1'b1, 8'hFF);
        offer(1'b1, "H");
        settle(1'b1);

        // steady mode error tone
        load_timing(0, 1, 1, 1, 1, 2, 3);
        offer(1'b1, 8'h00);
        offer(1'b1, "O");
        offer(1'b1, "S");
        settle(1'b1);

        // longest dash and tone, dot-only letters
        load_timing(1, 1, TIMER_MAX, 0, 0, TONE_MAX, TIMER_MAX);
        offer(1'b1, "E");
        offer(1'b1, "I");
        offer(1'b1, "S");
        offer(1'b1, "H");
        offer(1'b1, 8'hFF);
        settle(1'b1);

        // every timing at its maximum, tone mode errors only
        load_timing(1, TIMER_MAX, TIMER_MAX, TIMER_MAX, TIMER_MAX, TONE_MAX, TIMER_MAX);
        offer(1'b0, "A");
        offer(1'b1, 8'h00);
        offer(1'b1, 8'h7F);
        settle(1'b1);

        for (int regime = 0; regime < 3; regime++)
        begin
            send_gap_pct = (regime == 0) ? 18 : (regime == 1) ? 52 : 0;
            stall_pct    = (regime == 0) ? 52 : (regime == 1) ? 18 : 0;
            for (int s = 0; s < 3; s++)
            begin
                settle(1'b1);
                load_timing($urandom_range(1), $urandom_range(4, 1), $urandom_range(8, 1),
                            $urandom_range(3), $urandom_range(4), $urandom_range(6, 1),
                            $urandom_range(12));
                for (int half_run = 0; half_run < 2; half_run++)
                begin
                    for (int n = 0; n < 72; n++)
                    begin
                        if ($urandom_range(9) < 8)
                            offer($urandom_range(99) < 60,
                                  mlk_pkg::CODE_A + 8'($urandom_range(25)));
                        else
                            offer($urandom_range(99) < 60, 8'($urandom));
                    end
                    // sender holds off until every result is back
                    if (half_run == 0)
                        settle(1'b0);
                end
            end
        end

        settle(1'b1);
        repeat (10) @(negedge clk);
        if (predicted_pins.size() != 0)
            $display("%0t %0d expected words never arrived", $time, predicted_pins.size());
        if (mismatches == 0 && predicted_pins.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
